### hdl/wabd_pkg.sv
// Shared types, register indexes, reset values and display codes for the window alarm block.
// Depends on nothing; every other file of the block imports it.
package wabd_pkg;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ON_RELOAD  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_RELOAD = 2'd3;

    // Register and state reset values.
    localparam logic [7:0]  LOW_LIMIT_RST  = 8'd10;
    localparam logic [7:0]  HIGH_LIMIT_RST = 8'd25;
    localparam logic [15:0] ON_RELOAD_RST  = 16'd61785;
    localparam logic [15:0] OFF_RELOAD_RST = 16'd64285;

    // Display bytes.
    localparam logic [7:0] CURSOR_CMD  = 8'hC6;
    localparam logic [7:0] DEGREE_SIGN = 8'hDF;
    localparam logic [7:0] CHAR_C      = 8'h43;
    localparam logic [7:0] ASCII_ZERO  = 8'd48;

    // Input command codes.
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // Word positions within the six-word display run of a sample.
    localparam logic [2:0] BEAT_CURSOR   = 3'd0;
    localparam logic [2:0] BEAT_HUNDREDS = 3'd1;
    localparam logic [2:0] BEAT_TENS     = 3'd2;
    localparam logic [2:0] BEAT_ONES     = 3'd3;
    localparam logic [2:0] BEAT_DEGREE   = 3'd4;
    localparam logic [2:0] BEAT_UNIT     = 3'd5;

    // Configuration register set.
    typedef struct packed {
        logic [7:0]  low_limit;
        logic [7:0]  high_limit;
        logic [15:0] on_reload;
        logic [15:0] off_reload;
    } wabd_cfg_t;

    // One result word.
    typedef struct packed {
        logic       speaker;
        logic       disp_valid;
        logic       disp_is_data;
        logic [7:0] disp_byte;
        logic       last;
    } wabd_beat_t;

    // Decimal digits of an 8-bit value.
    typedef struct packed {
        logic [3:0] hundreds;
        logic [3:0] tens;
        logic [3:0] ones;
    } wabd_digits_t;

    // Splits a byte into decimal digits: compares for the hundreds, then a
    // multiply by 205/2048 for the tens of the remainder below one hundred.
    function automatic wabd_digits_t to_digits(input logic [7:0] value);
        wabd_digits_t d;
        logic [7:0]   rem;
        logic [14:0]  prod;
        logic [7:0]   tens_x10;
        if (value >= 8'd200) begin
            d.hundreds = 4'd2;
            rem        = value - 8'd200;
        end
        else if (value >= 8'd100) begin
            d.hundreds = 4'd1;
            rem        = value - 8'd100;
        end
        else begin
            d.hundreds = 4'd0;
            rem        = value;
        end
        prod     = 15'(rem[6:0]) * 15'd205;
        d.tens   = prod[14:11];
        tens_x10 = {4'd0, d.tens} * 8'd10;
        d.ones   = 4'(rem - tens_x10);
        return d;
    endfunction

endpackage

### hdl/wabd_cfg.sv
// Configuration register file for the window alarm block.
// Depends on wabd_pkg for register indexes, reset values and the register struct.
module wabd_cfg
    import wabd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data,
    output wabd_cfg_t            cfg
);

    wabd_cfg_t cfg_reg;
    wabd_cfg_t cfg_next;

    // Writes are always taken.
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Decode the register index of a write.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_LOW_LIMIT:  cfg_next.low_limit  = cfg_data[7:0];
                REG_HIGH_LIMIT: cfg_next.high_limit = cfg_data[7:0];
                REG_ON_RELOAD:  cfg_next.on_reload  = cfg_data;
                REG_OFF_RELOAD: cfg_next.off_reload = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.low_limit  <= LOW_LIMIT_RST;
            cfg_reg.high_limit <= HIGH_LIMIT_RST;
            cfg_reg.on_reload  <= ON_RELOAD_RST;
            cfg_reg.off_reload <= OFF_RELOAD_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### hdl/wabd_ctrl.sv
// Input register, alarm and tone state, and the word sequencer of the window alarm block.
// Depends on wabd_pkg for the register and word structs, codes and the digit function.
module wabd_ctrl
    import wabd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  wabd_cfg_t  cfg,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       in_command,
    input  logic [7:0] in_sample,
    input  logic       beat_ready,
    output logic       beat_valid,
    output wabd_beat_t beat
);

    logic        in_vld_reg;
    logic        in_vld_next;
    logic        in_cmd_reg;
    logic [7:0]  in_sample_reg;
    logic [2:0]  beat_reg;
    logic [2:0]  beat_next;
    logic        speaker_reg;
    logic        speaker_next;
    logic        running_reg;
    logic        running_next;
    logic [15:0] counter_reg;
    logic [15:0] counter_next;

    logic         issue;
    logic         last_beat;
    logic         done;
    logic         accept;
    logic         update_en;
    logic         outside;
    wabd_digits_t digits;

    // Handshake between the input register and the sequencer.
    assign issue     = in_vld_reg && beat_ready;
    assign last_beat = (in_cmd_reg == CMD_TICK) || (beat_reg == BEAT_UNIT);
    assign done      = issue && last_beat;
    assign in_ready  = !in_vld_reg || done;
    assign accept    = in_valid && in_ready;
    assign update_en = issue && (beat_reg == BEAT_CURSOR);

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (accept)
            in_vld_next = 1'b1;
        else if (done)
            in_vld_next = 1'b0;
        beat_next = beat_reg;
        if (done)
            beat_next = BEAT_CURSOR;
        else if (issue)
            beat_next = beat_reg + 3'd1;
    end

    // Alarm window and tone timer, updated once per item on its first word.
    assign outside = (in_sample_reg < cfg.low_limit) || (in_sample_reg > cfg.high_limit);

    always_comb
    begin
        speaker_next = speaker_reg;
        running_next = running_reg;
        counter_next = counter_reg;
        if (update_en)
        begin
            if (in_cmd_reg == CMD_TICK)
            begin
                if (running_reg)
                begin
                    if (counter_reg == 16'hFFFF)
                    begin
                        speaker_next = !speaker_reg;
                        counter_next = speaker_reg ? cfg.off_reload : cfg.on_reload;
                    end
                    else
                    begin
                        counter_next = counter_reg + 16'd1;
                    end
                end
            end
            else if (outside)
            begin
                speaker_next = 1'b1;
                running_next = 1'b1;
            end
            else
            begin
                if (running_reg)
                    counter_next = cfg.on_reload;
                running_next = 1'b0;
                speaker_next = 1'b0;
            end
        end
    end

    // Word content for the current position of the run.
    assign digits = to_digits(in_sample_reg);

    always_comb
    begin
        beat.speaker      = speaker_next;
        beat.disp_valid   = 1'b1;
        beat.disp_is_data = 1'b1;
        beat.last         = 1'b0;
        beat.disp_byte    = 8'd0;
        if (in_cmd_reg == CMD_TICK)
        begin
            beat.disp_valid   = 1'b0;
            beat.disp_is_data = 1'b0;
            beat.last         = 1'b1;
        end
        else
        begin
            case (beat_reg)
                BEAT_CURSOR:
                begin
                    beat.disp_is_data = 1'b0;
                    beat.disp_byte    = CURSOR_CMD;
                end
                BEAT_HUNDREDS: beat.disp_byte = ASCII_ZERO + {4'd0, digits.hundreds};
                BEAT_TENS:     beat.disp_byte = ASCII_ZERO + {4'd0, digits.tens};
                BEAT_ONES:     beat.disp_byte = ASCII_ZERO + {4'd0, digits.ones};
                BEAT_DEGREE:   beat.disp_byte = DEGREE_SIGN;
                BEAT_UNIT:
                begin
                    beat.disp_byte = CHAR_C;
                    beat.last      = 1'b1;
                end
                default:       beat.disp_byte = 8'd0;
            endcase
        end
    end

    assign beat_valid = in_vld_reg;

    // Control state and block state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            beat_reg    <= BEAT_CURSOR;
            speaker_reg <= 1'b0;
            running_reg <= 1'b0;
            counter_reg <= ON_RELOAD_RST;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            beat_reg    <= beat_next;
            speaker_reg <= speaker_next;
            running_reg <= running_next;
            counter_reg <= counter_next;
        end
    end

    // Input payload register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_cmd_reg    <= in_command;
            in_sample_reg <= in_sample;
        end
    end

endmodule

### hdl/wabd_out.sv
// Output register of the window alarm block; holds one result word toward the stream.
// Depends on wabd_pkg for the result word struct.
module wabd_out
    import wabd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       beat_valid,
    output logic       beat_ready,
    input  wabd_beat_t beat,
    output logic       out_valid,
    input  logic       out_ready,
    output wabd_beat_t out_beat
);

    logic       out_vld_reg;
    logic       out_vld_next;
    wabd_beat_t out_beat_reg;
    logic       load;

    // The register takes a new word when it is empty or being drained.
    assign beat_ready = !out_vld_reg || out_ready;
    assign load       = beat_valid && beat_ready;

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (load)
            out_vld_next = 1'b1;
        else if (out_ready)
            out_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else
            out_vld_reg <= out_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_beat_reg <= beat;
    end

    assign out_valid = out_vld_reg;
    assign out_beat  = out_beat_reg;

endmodule

### hdl/window_alarm_beeper_display_top.sv
// Top level of the window alarm block; depends on wabd_pkg, wabd_cfg, wabd_ctrl and wabd_out.
// Flow: an accepted word is held in the input register, and its result words go from there
// through the single output register onto the stream; a stalled output holds them back.
// Output: a tick yields one result word, a sample six display words; the next input word
// is accepted when the last result word of the current one is issued.
// Reset (rst_n low, asynchronous): default registers, speaker off, timer stopped, sides empty.
module window_alarm_beeper_display_top
    import wabd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Configuration write channel.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data,
    // Input stream.
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,  // [7:0] sample
    input  logic                 s_axis_tuser,  // [0] command
    // Output stream.
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [15:0]          m_axis_tdata,  // [0] speaker, [8:1] display_byte, rest zero
    output logic [1:0]           m_axis_tuser,  // [0] display_valid, [1] display_is_data
    output logic                 m_axis_tlast
);

    wabd_cfg_t  cfg;
    logic       beat_valid;
    logic       beat_ready;
    wabd_beat_t beat;
    wabd_beat_t out_beat;

    wabd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    wabd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_command (s_axis_tuser),
        .in_sample  (s_axis_tdata),
        .beat_ready (beat_ready),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    wabd_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .beat_valid (beat_valid),
        .beat_ready (beat_ready),
        .beat       (beat),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_beat   (out_beat)
    );

    // Pack the result word onto the stream.
    assign m_axis_tdata = {7'd0, out_beat.disp_byte, out_beat.speaker};
    assign m_axis_tuser = {out_beat.disp_is_data, out_beat.disp_valid};
    assign m_axis_tlast = out_beat.last;

endmodule

### hdl/wabd_checker.sv
// Port-level checks for the window alarm block, bound to the top level.
// Depends on wabd_pkg for the display codes.
module wabd_checker
    import wabd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    logic out_fire;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    // A tick word carries no display byte and closes its run.
    a_tick_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && !m_axis_tuser[0] |-> m_axis_tlast && m_axis_tdata[8:1] == 8'd0
                                         && !m_axis_tuser[1])
        else $error("tick word malformed");

    // The only display command is the cursor command that opens a run.
    a_cursor_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && m_axis_tuser[0] && !m_axis_tuser[1] |->
            m_axis_tdata[8:1] == CURSOR_CMD && !m_axis_tlast)
        else $error("display command word malformed");

    // The last word of a display run is the unit letter.
    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && m_axis_tuser[0] && m_axis_tlast |-> m_axis_tdata[8:1] == CHAR_C)
        else $error("display run does not end with the unit letter");

    // A stalled word stays on the bus with its data and last flag unchanged.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                            && $stable(m_axis_tlast))
        else $error("stalled word changed");

endmodule

bind window_alarm_beeper_display_top wabd_checker u_wabd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
